[sv/tksd_pkg.sv]
// Package for the terminal key sequence decoder.
// Holds event codes, buffer sizing and the front-to-back record type.
package tksd_pkg;

  localparam int BUF_BYTES = 32;
  localparam int CNT_W = $clog2(BUF_BYTES + 1);

  localparam logic [2:0] EV_KEY   = 3'd0;
  localparam logic [2:0] EV_PASTE = 3'd1;
  localparam logic [2:0] EV_PBEG  = 3'd2;
  localparam logic [2:0] EV_PEND  = 3'd3;
  localparam logic [2:0] EV_MOUSE = 3'd4;

  localparam logic [3:0] SK_NONE  = 4'd0;
  localparam logic [3:0] SK_UP    = 4'd1;
  localparam logic [3:0] SK_DOWN  = 4'd2;
  localparam logic [3:0] SK_RIGHT = 4'd3;
  localparam logic [3:0] SK_LEFT  = 4'd4;
  localparam logic [3:0] SK_HOME  = 4'd5;
  localparam logic [3:0] SK_END   = 4'd6;
  localparam logic [3:0] SK_PGUP  = 4'd7;
  localparam logic [3:0] SK_PGDN  = 4'd8;
  localparam logic [3:0] SK_OTHER = 4'd9;

  localparam logic [7:0] ESC_BYTE = 8'h1b;
  localparam logic [20:0] REPLACEMENT = 21'h00fffd;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [20:0] code_point;
    logic [3:0]  special_key;
    logic [4:0]  sequence_length;
    logic [15:0] mouse_x;
    logic [15:0] mouse_y;
    logic [15:0] mouse_button;
    logic        mouse_release;
  } event_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

endpackage

[sv/tksd_if.sv]
// Valid/ready channel interfaces for request and event transactions.
// Depends on tksd_pkg for the payload types.
interface tksd_req_if;
  logic          valid;
  logic          ready;
  tksd_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tksd_evt_if;
  logic            valid;
  logic            ready;
  tksd_pkg::event_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/tksd_front.sv]
// Front part: accepts requests into a two-entry queue.
// Depends on tksd_pkg and tksd_if.
module tksd_front (
  input  logic      clk,
  input  logic      rst,
  tksd_req_if.sink  req_in,
  tksd_req_if.source req_out
);

  tksd_pkg::req_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign req_in.ready  = (cnt != 2'd2);
  assign req_out.valid = (cnt != 2'd0);
  assign req_out.payload = mem[rp];
  assign push = req_in.valid && req_in.ready;
  assign pop  = req_out.valid && req_out.ready;

  // Store and advance queue pointers
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= req_in.payload;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[sv/tksd_back.sv]
// Back part: decodes one request a cycle into zero or one event while
// its one-entry output register is free or drained. Uses tksd_pkg, tksd_if.
module tksd_back (
  input  logic       clk,
  input  logic       rst,
  tksd_req_if.sink   req_in,
  tksd_evt_if.source evt_out
);

  localparam int CW = tksd_pkg::CNT_W;

  logic [CW-1:0] seq_count, seq_count_next;
  logic [7:0]  head_bytes [3];
  logic        paste_mode, paste_mode_next;
  logic        discard_mode, discard_mode_next;
  logic [1:0]  legacy_skip, legacy_skip_next;
  logic [20:0] utf8_value, utf8_value_next;
  logic [1:0]  utf8_needed, utf8_needed_next;
  logic [16:0] mouse_fields [3];
  logic [16:0] mf_next [3];
  logic [1:0]  mouse_index, mouse_index_next;
  logic        mouse_valid, mouse_valid_next;
  logic [3:0]  pattern_match, pattern_match_next;

  logic        out_valid;
  tksd_pkg::event_t out_evt;
  logic        fire, emit;
  tksd_pkg::event_t ev;

  logic        take;
  logic [7:0]  b;
  logic        fin, wr_head;
  logic [7:0]  h0, h1, h2;
  logic [CW-1:0] pos;

  // Accept when the output register is free or being drained
  assign take = !out_valid || evt_out.ready;
  assign req_in.ready = take;
  assign fire = req_in.valid && take;
  assign evt_out.valid = out_valid;
  assign evt_out.payload = out_evt;
  assign b = req_in.payload.data_byte;
  assign fin = (b >= 8'h40) && (b <= 8'h7e);
  assign pos = seq_count;

  // Decode one request
  always_comb begin
    logic [2:0]  kind;
    logic [4:0]  sc5;
    logic [CW-1:0] cnt1;
    logic [16:0] vacc;
    logic [1:0]  idx;
    logic [20:0] v;
    logic [15:0] bx, by;
    logic [7:0]  pat [4][6];
    logic [2:0]  plen [4];
    logic [3:0]  sk;
    seq_count_next = seq_count;
    paste_mode_next = paste_mode;
    discard_mode_next = discard_mode;
    legacy_skip_next = legacy_skip;
    utf8_value_next = utf8_value;
    utf8_needed_next = utf8_needed;
    mf_next = mouse_fields;
    mouse_index_next = mouse_index;
    mouse_valid_next = mouse_valid;
    pattern_match_next = pattern_match;
    emit = 1'b0;
    ev = '0;
    wr_head = 1'b0;
    h0 = head_bytes[0]; h1 = head_bytes[1]; h2 = head_bytes[2];
    kind = paste_mode ? tksd_pkg::EV_PASTE : tksd_pkg::EV_KEY;
    cnt1 = seq_count + 1'b1;
    sc5 = cnt1[4:0];
    vacc = '0; idx = '0; v = '0; bx = '0; by = '0; sk = tksd_pkg::SK_OTHER;
    pat[0] = '{8'h1b, "[", "2", "0", "0", "~"};
    pat[1] = '{8'h1b, "[", "2", "0", "1", "~"};
    pat[2] = '{8'h1b, "[", "5", "~", 8'h00, 8'h00};
    pat[3] = '{8'h1b, "[", "6", "~", 8'h00, 8'h00};
    plen = '{3'd6, 3'd6, 3'd4, 3'd4};
    if (req_in.payload.req_type) begin
      // Flush: lone ESC or partial UTF-8 run gives an event, else clear skip state
      if ((seq_count == CW'(1) && h0 == tksd_pkg::ESC_BYTE) ||
          (seq_count != '0 && h0[7])) begin
        emit = 1'b1;
        ev.event_kind = kind;
        ev.code_point = (seq_count == CW'(1) && h0 == tksd_pkg::ESC_BYTE)
                        ? 21'd27 : 21'd63;
        ev.special_key = tksd_pkg::SK_NONE;
        ev.sequence_length = seq_count[4:0];
      end else begin
        discard_mode_next = 1'b0;
        legacy_skip_next = '0;
      end
      seq_count_next = '0;
      utf8_needed_next = '0;
    end else if (legacy_skip != '0) begin
      legacy_skip_next = legacy_skip - 2'd1;
    end else if (discard_mode) begin
      if (fin) begin
        discard_mode_next = 1'b0;
        seq_count_next = '0;
      end
    end else if (seq_count >= CW'(tksd_pkg::BUF_BYTES - 1)) begin
      discard_mode_next = !fin;
      seq_count_next = '0;
      utf8_needed_next = '0;
    end else begin
      if (pos < CW'(3)) begin
        wr_head = 1'b1;
        if (pos == CW'(0)) h0 = b;
        else if (pos == CW'(1)) h1 = b;
        else h2 = b;
      end
      seq_count_next = cnt1;
      // Track prefix patterns and SGR mouse fields
      if (pos == '0) begin
        pattern_match_next = 4'hf;
        mf_next[0] = '0; mf_next[1] = '0; mf_next[2] = '0;
        mouse_index_next = '0;
        mouse_valid_next = 1'b1;
      end
      for (int k = 0; k < 4; k++) begin
        if (pos >= CW'(plen[k])) pattern_match_next[k] = 1'b0;
        else if (pat[k][pos[2:0]] != b) pattern_match_next[k] = 1'b0;
      end
      if (pos >= CW'(3)) begin
        if (b >= "0" && b <= "9") begin
          idx = (mouse_index < 2'd3) ? mouse_index : 2'd2;
          vacc = {1'b0, mouse_fields[idx][15:0]} * 17'd10 + {13'd0, b[3:0]};
          if (mouse_fields[idx][15:0] > 16'd6553 || vacc > 17'd65535)
            mouse_valid_next = 1'b0;
          else mf_next[idx] = {1'b1, vacc[15:0]};
        end else if (b == ";") begin
          if (mouse_index < 2'd2 && mouse_fields[mouse_index][16])
            mouse_index_next = mouse_index + 2'd1;
          else mouse_valid_next = 1'b0;
        end else if (b != "m" && b != "M") begin
          mouse_valid_next = 1'b0;
        end
      end
      ev.sequence_length = sc5;
      if (h0[7]) begin
        // UTF-8 assembly
        if (pos == '0) begin
          if (b < 8'hc0 || b >= 8'hf8) begin
            emit = 1'b1; ev.event_kind = kind; ev.code_point = tksd_pkg::REPLACEMENT;
          end else if (b < 8'he0) begin
            utf8_needed_next = 2'd1; utf8_value_next = {16'd0, b[4:0]};
          end else if (b < 8'hf0) begin
            utf8_needed_next = 2'd2; utf8_value_next = {17'd0, b[3:0]};
          end else begin
            utf8_needed_next = 2'd3; utf8_value_next = {18'd0, b[2:0]};
          end
        end else if (b[7:6] != 2'b10) begin
          emit = 1'b1; ev.event_kind = kind; ev.code_point = tksd_pkg::REPLACEMENT;
        end else begin
          v = {utf8_value[14:0], b[5:0]};
          utf8_value_next = v;
          if (utf8_needed > 2'd1) utf8_needed_next = utf8_needed - 2'd1;
          else begin
            if ((cnt1 == CW'(2) && v < 21'h80) || (cnt1 == CW'(3) && v < 21'h800) ||
                (cnt1 >= CW'(4) && v < 21'h10000) ||
                (v >= 21'hd800 && v <= 21'hdfff) || v > 21'h10ffff)
              v = tksd_pkg::REPLACEMENT;
            emit = 1'b1; ev.event_kind = kind; ev.code_point = v;
          end
        end
      end else if (h0 != tksd_pkg::ESC_BYTE) begin
        emit = 1'b1; ev.event_kind = kind; ev.code_point = {13'd0, b};
      end else if (cnt1 == CW'(1)) begin
        emit = 1'b0;
      end else if (h1 != "[" && h1 != "O") begin
        emit = 1'b1; ev.event_kind = kind; ev.special_key = tksd_pkg::SK_OTHER;
      end else if (cnt1 < CW'(3) || !fin) begin
        emit = 1'b0;
      end else if (cnt1 == CW'(3) && h1 == "[" && b == "M" && !paste_mode) begin
        legacy_skip_next = 2'd3;
        seq_count_next = '0;
      end else if (pattern_match_next[0] && cnt1 == CW'(6)) begin
        paste_mode_next = 1'b1;
        emit = 1'b1; ev.event_kind = tksd_pkg::EV_PBEG; ev.special_key = tksd_pkg::SK_OTHER;
      end else if (pattern_match_next[1] && cnt1 == CW'(6)) begin
        paste_mode_next = 1'b0;
        emit = 1'b1; ev.event_kind = tksd_pkg::EV_PEND; ev.special_key = tksd_pkg::SK_OTHER;
      end else if (paste_mode) begin
        emit = 1'b1; ev.event_kind = tksd_pkg::EV_PASTE; ev.special_key = tksd_pkg::SK_OTHER;
      end else if (h2 == "<") begin
        bx = mf_next[1][15:0];
        by = mf_next[2][15:0];
        if (!mouse_valid_next || mouse_index_next != 2'd2 || !mf_next[2][16] ||
            (b != "m" && b != "M") || bx == '0 || by == '0) begin
          seq_count_next = '0;
        end else begin
          emit = 1'b1;
          ev.event_kind = tksd_pkg::EV_MOUSE;
          ev.special_key = tksd_pkg::SK_OTHER;
          ev.mouse_x = bx - 16'd1;
          ev.mouse_y = by - 16'd1;
          ev.mouse_button = mf_next[0][15:0];
          ev.mouse_release = (b == "m");
        end
      end else begin
        if (cnt1 == CW'(3)) begin
          case (b)
            "A": sk = tksd_pkg::SK_UP;
            "B": sk = tksd_pkg::SK_DOWN;
            "C": sk = tksd_pkg::SK_RIGHT;
            "D": sk = tksd_pkg::SK_LEFT;
            "H": sk = tksd_pkg::SK_HOME;
            "F": sk = tksd_pkg::SK_END;
            default: sk = tksd_pkg::SK_OTHER;
          endcase
        end else if (pattern_match_next[2] && cnt1 == CW'(4)) sk = tksd_pkg::SK_PGUP;
        else if (pattern_match_next[3] && cnt1 == CW'(4)) sk = tksd_pkg::SK_PGDN;
        emit = 1'b1; ev.event_kind = tksd_pkg::EV_KEY; ev.special_key = sk;
      end
      if (emit) begin
        seq_count_next = '0;
        utf8_needed_next = '0;
      end
    end
  end

  // Hold decoder state and the output register
  always_ff @(posedge clk) begin
    if (fire && wr_head) begin
      head_bytes[0] <= h0; head_bytes[1] <= h1; head_bytes[2] <= h2;
    end
    if (fire && emit) out_evt <= ev;
    if (rst) begin
      seq_count <= '0; paste_mode <= 1'b0; discard_mode <= 1'b0;
      legacy_skip <= '0; utf8_value <= '0; utf8_needed <= '0;
      mouse_fields[0] <= '0; mouse_fields[1] <= '0; mouse_fields[2] <= '0;
      mouse_index <= '0; mouse_valid <= 1'b1; pattern_match <= 4'hf;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        seq_count <= seq_count_next; paste_mode <= paste_mode_next;
        discard_mode <= discard_mode_next; legacy_skip <= legacy_skip_next;
        utf8_value <= utf8_value_next; utf8_needed <= utf8_needed_next;
        mouse_fields <= mf_next; mouse_index <= mouse_index_next;
        mouse_valid <= mouse_valid_next; pattern_match <= pattern_match_next;
      end
      if (fire) out_valid <= emit;
      else if (evt_out.ready) out_valid <= 1'b0;
    end
  end

endmodule

[sv/terminal_key_sequence_decoder.sv]
// Top level of the terminal key sequence decoder.
// Depends on tksd_pkg, tksd_if, tksd_front and tksd_back.
//
// Takes one byte or flush request per cycle while the queue has room, and gives
// at most one key, paste or mouse event for it; the decoder back end updates its
// state once per request, and a two-entry request queue and an output register
// let input and output stall independently. An event appears on the output in
// the cycle after its request leaves the queue.
module terminal_key_sequence_decoder (
  input  logic       clk,
  input  logic       rst,
  tksd_req_if.sink   req,
  tksd_evt_if.source evt
);

  tksd_req_if q ();

  tksd_front u_front (.clk(clk), .rst(rst), .req_in(req), .req_out(q.source));
  tksd_back u_back (.clk(clk), .rst(rst), .req_in(q.sink), .evt_out(evt));

endmodule
